// File: hdl/csma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csma_pkg: shared types and constants of the CSMA-CA channel access engine
// Field widths, event and action codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package csma_pkg;

    // Field and state widths
    localparam int WIN_W      = 18;
    localparam int TX_W       = 9;
    localparam int STEP_W     = 5;
    localparam int LEN_W      = 8;
    localparam int RSSI_W     = 9;
    localparam int RND_W      = 16;
    localparam int DELAY_W    = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int GUARD_W    = 8;
    localparam int GAP_W      = 8;
    localparam int CMD_W      = 2;
    localparam int ACT_W      = 3;
    localparam int MODE_W     = 2;
    localparam int RATE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Event codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELAY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RSSI  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CLASS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 3'd5;

    // Backoff modes
    localparam logic [MODE_W-1:0] MODE_UNCON = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AIND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAIND = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RIGD  = 2'd3;

    // Rate classes and their byte divisors
    localparam logic [RATE_W-1:0] RATE_LOW    = 2'd0;
    localparam logic [RATE_W-1:0] RATE_NORMAL = 2'd1;
    localparam logic [RATE_W-1:0] RATE_HIGH   = 2'd2;
    localparam logic [LEN_W-1:0]  DIV_LOW     = 8'd1;
    localparam logic [LEN_W-1:0]  DIV_NORMAL  = 8'd6;
    localparam logic [LEN_W-1:0]  DIV_HIGH    = 8'd20;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0]        RATE_RESET  = RATE_NORMAL;
    localparam logic signed [RSSI_W-1:0] THR_RESET   = -9'sd86;
    localparam logic [GUARD_W-1:0]       GUARD_RESET = 8'd5;
    localparam logic [GAP_W-1:0]         GAP_RESET   = 8'd5;

    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_WAIT,
        ACT_MEASURE,
        ACT_TX,
        ACT_FAIL,
        ACT_REJECT
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    // Operand pairs of the shared divider
    typedef enum logic [1:0] {
        DIV_LEN_RATE,
        DIV_WIN_TX,
        DIV_RND_SLOTS,
        DIV_RND_HALF
    } div_sel_t;

    // Start offset updates
    typedef enum logic [1:0] {
        OFS_HOLD,
        OFS_ZERO,
        OFS_MUL,
        OFS_REM
    } ofs_op_t;

    // Result commits: each writes the output register, and all but reject and start failure also the phase state
    typedef enum logic [2:0] {
        RES_NONE,
        RES_REJECT,
        RES_FAIL_START,
        RES_FAIL_BUSY,
        RES_MEAS,
        RES_GAP,
        RES_TX,
        RES_LAUNCH
    } res_op_t;

    typedef struct packed {
        logic     load_in;
        logic     start_clear;
        logic     div_start;
        div_sel_t div_sel;
        logic     tx_load;
        logic     win_start;
        logic     win_busy;
        logic     slots_load;
        ofs_op_t  ofs_op;
        res_op_t  res_op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        phase_t            phase;
        logic              check_second;
        logic              chan_clear;
        logic              guard_fail;
        logic              tca_pos;
        logic [MODE_W-1:0] mode;
        logic              tx_zero;
        logic              slots_zero;
        logic              half_zero;
        logic              div_done;
        logic              out_free;
    } dp_status_t;

    // Byte divisor of a rate class; the unused class behaves as normal rate
    function automatic logic [LEN_W-1:0] rate_divisor(input logic [RATE_W-1:0] rc);
        logic [LEN_W-1:0] d;
        case (rc)
            RATE_LOW:  d = DIV_LOW;
            RATE_HIGH: d = DIV_HIGH;
            default:   d = DIV_NORMAL;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// File: hdl/csma_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csma_div: serial restoring divider
// One quotient bit per cycle; quotient and remainder hold after done pulses.
// The divisor must be nonzero.
// ----------------------------------------------------------------------------
module csma_div #(
    parameter int W = csma_pkg::WIN_W
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0]       rem_shift;
    logic [W:0]       rem_sub;
    logic             ge;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        ge        = (rem_shift >= {1'b0, dvs_reg});
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[W-1:0] : rem_shift[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// File: hdl/csma_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csma_dp: channel access datapath
// Configuration registers, event capture, access window state, offset draws
// through the shared divider and the output register.
// ----------------------------------------------------------------------------
module csma_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [csma_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [csma_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [csma_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic [csma_pkg::CMD_W-1:0]          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [csma_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic [csma_pkg::ACT_W-1:0]               m_tuser,
    input  wire csma_pkg::dp_cmd_t                   cmd,
    output csma_pkg::dp_status_t                     status
);

    localparam int WIN_W = csma_pkg::WIN_W;
    localparam int TX_W  = csma_pkg::TX_W;
    localparam int SH_W  = csma_pkg::STEP_W + 1;
    localparam int TCA_W = csma_pkg::TIMEOUT_W + 1;
    localparam int MUL_W = csma_pkg::RND_W + TX_W;

    // Configuration
    logic [csma_pkg::MODE_W-1:0]         mode_reg;
    logic [csma_pkg::TIMEOUT_W-1:0]      timeout_reg;
    logic [csma_pkg::RATE_W-1:0]         rate_reg;
    logic signed [csma_pkg::RSSI_W-1:0]  thr_reg;
    logic [csma_pkg::GUARD_W-1:0]        guard_reg;
    logic [csma_pkg::GAP_W-1:0]          gap_reg;

    // Captured event
    logic [csma_pkg::CMD_W-1:0]          cmd_reg;
    logic [csma_pkg::LEN_W-1:0]          len_reg;
    logic signed [csma_pkg::RSSI_W-1:0]  rssi_reg;
    logic [csma_pkg::RND_W-1:0]          rnd_reg;

    // Access state
    csma_pkg::phase_t                    phase_reg;
    logic [TX_W-1:0]                     tx_reg;
    logic [WIN_W-1:0]                    win_now_reg;
    logic [WIN_W-1:0]                    win_first_reg;
    logic [WIN_W-1:0]                    time_left_reg;
    logic [csma_pkg::STEP_W-1:0]         step_reg;
    logic                                check_reg;
    logic [WIN_W-1:0]                    slots_reg;
    logic [WIN_W-1:0]                    offset_reg;

    // Output register
    logic                                out_valid_reg;
    csma_pkg::action_t                   act_reg;
    logic [csma_pkg::DELAY_W-1:0]        delay_reg;

    logic signed [TCA_W-1:0]             tca;
    logic                                tca_pos;
    logic [SH_W-1:0]                     sh;
    logic [WIN_W-1:0]                    half;
    logic [MUL_W-1:0]                    mul;
    logic [WIN_W-1:0]                    left_next;
    logic                                out_free;
    logic [WIN_W-1:0]                    div_dividend;
    logic [WIN_W-1:0]                    div_divisor;
    logic                                div_done;
    logic [WIN_W-1:0]                    div_quo;
    logic [WIN_W-1:0]                    div_rem;

    // Window, halving slot, slotted offset and remaining time
    always_comb
    begin
        tca       = $signed({1'b0, timeout_reg}) - $signed(TCA_W'(tx_reg));
        tca_pos   = !tca[TCA_W-1] && (tca != '0);
        sh        = SH_W'(step_reg) + SH_W'(1);
        half      = (sh >= SH_W'(WIN_W)) ? '0 : (win_first_reg >> sh);
        mul       = div_rem[csma_pkg::RND_W-1:0] * tx_reg;
        left_next = win_now_reg - offset_reg;
        out_free  = !out_valid_reg || m_tready;
    end

    // Select divider operands
    always_comb
    begin
        unique case (cmd.div_sel)
            csma_pkg::DIV_LEN_RATE:
            begin
                div_dividend = WIN_W'(len_reg);
                div_divisor  = WIN_W'(csma_pkg::rate_divisor(rate_reg));
            end
            csma_pkg::DIV_WIN_TX:
            begin
                div_dividend = win_now_reg;
                div_divisor  = WIN_W'(tx_reg);
            end
            csma_pkg::DIV_RND_SLOTS:
            begin
                div_dividend = WIN_W'(rnd_reg);
                div_divisor  = slots_reg;
            end
            csma_pkg::DIV_RND_HALF:
            begin
                div_dividend = WIN_W'(rnd_reg);
                div_divisor  = half;
            end
        endcase
    end

    csma_div #(
        .W (WIN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= csma_pkg::MODE_UNCON;
            timeout_reg <= '0;
            rate_reg    <= csma_pkg::RATE_RESET;
            thr_reg     <= csma_pkg::THR_RESET;
            guard_reg   <= csma_pkg::GUARD_RESET;
            gap_reg     <= csma_pkg::GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                csma_pkg::CFG_ACCESS_MODE: mode_reg    <= cfg_data[csma_pkg::MODE_W-1:0];
                csma_pkg::CFG_TIMEOUT:     timeout_reg <= cfg_data[csma_pkg::TIMEOUT_W-1:0];
                csma_pkg::CFG_RATE_CLASS:  rate_reg    <= cfg_data[csma_pkg::RATE_W-1:0];
                csma_pkg::CFG_THRESHOLD:   thr_reg     <= $signed(cfg_data[csma_pkg::RSSI_W-1:0]);
                csma_pkg::CFG_GUARD:       guard_reg   <= cfg_data[csma_pkg::GUARD_W-1:0];
                csma_pkg::CFG_GAP:         gap_reg     <= cfg_data[csma_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the event on an input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg  <= s_tuser;
            len_reg  <= s_tdata[7:0];
            rssi_reg <= $signed(s_tdata[16:8]);
            rnd_reg  <= s_tdata[32:17];
        end
    end

    // Slot count and start offset
    always_ff @(posedge clk)
    begin
        if (cmd.slots_load)
        begin
            slots_reg <= div_quo;
        end
        unique case (cmd.ofs_op)
            csma_pkg::OFS_HOLD: ;
            csma_pkg::OFS_ZERO: offset_reg <= '0;
            csma_pkg::OFS_MUL:  offset_reg <= mul[WIN_W-1:0];
            csma_pkg::OFS_REM:  offset_reg <= div_rem;
        endcase
    end

    // Access state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= csma_pkg::PH_IDLE;
            tx_reg        <= '0;
            win_now_reg   <= '0;
            win_first_reg <= '0;
            time_left_reg <= '0;
            step_reg      <= '0;
            check_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            act_reg       <= csma_pkg::ACT_WAIT;
            delay_reg     <= '0;
        end
        else
        begin
            if (cmd.start_clear)
            begin
                step_reg  <= '0;
                check_reg <= 1'b0;
            end
            if (cmd.tx_load)
            begin
                tx_reg <= div_quo[TX_W-1:0] + TX_W'(1);
            end
            if (cmd.win_start)
            begin
                win_now_reg <= WIN_W'(tca[TCA_W-2:0]);
                if (mode_reg == csma_pkg::MODE_RIGD)
                begin
                    win_first_reg <= WIN_W'(tca[TCA_W-2:0]);
                end
            end
            if (cmd.win_busy)
            begin
                win_now_reg <= time_left_reg;
                if (mode_reg == csma_pkg::MODE_RIGD && step_reg != csma_pkg::STEP_MAX)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            // Drop the output once taken; a new commit refills it
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.res_op != csma_pkg::RES_NONE)
            begin
                out_valid_reg <= 1'b1;
                delay_reg     <= '0;
            end

            unique case (cmd.res_op)
                csma_pkg::RES_NONE: ;
                csma_pkg::RES_REJECT:
                begin
                    act_reg <= csma_pkg::ACT_REJECT;
                end
                csma_pkg::RES_FAIL_START:
                begin
                    act_reg <= csma_pkg::ACT_FAIL;
                end
                csma_pkg::RES_FAIL_BUSY:
                begin
                    act_reg   <= csma_pkg::ACT_FAIL;
                    phase_reg <= csma_pkg::PH_IDLE;
                    check_reg <= 1'b0;
                end
                csma_pkg::RES_MEAS:
                begin
                    act_reg   <= csma_pkg::ACT_MEASURE;
                    phase_reg <= csma_pkg::PH_MEAS;
                end
                csma_pkg::RES_GAP:
                begin
                    act_reg   <= csma_pkg::ACT_WAIT;
                    delay_reg <= csma_pkg::DELAY_W'(gap_reg);
                    phase_reg <= csma_pkg::PH_WAIT;
                    check_reg <= 1'b1;
                end
                csma_pkg::RES_TX:
                begin
                    act_reg   <= csma_pkg::ACT_TX;
                    phase_reg <= csma_pkg::PH_IDLE;
                    check_reg <= 1'b0;
                end
                csma_pkg::RES_LAUNCH:
                begin
                    time_left_reg <= left_next;
                    check_reg     <= 1'b0;
                    if (offset_reg != '0)
                    begin
                        act_reg   <= csma_pkg::ACT_WAIT;
                        delay_reg <= offset_reg[csma_pkg::DELAY_W-1:0];
                        phase_reg <= csma_pkg::PH_WAIT;
                    end
                    else
                    begin
                        act_reg   <= csma_pkg::ACT_MEASURE;
                        phase_reg <= csma_pkg::PH_MEAS;
                    end
                end
            endcase
        end
    end

    // Status toward the controller
    always_comb
    begin
        status.cmd          = cmd_reg;
        status.phase        = phase_reg;
        status.check_second = check_reg;
        status.chan_clear   = (rssi_reg <= thr_reg);
        status.guard_fail   = (time_left_reg < WIN_W'(guard_reg));
        status.tca_pos      = tca_pos;
        status.mode         = mode_reg;
        status.tx_zero      = (tx_reg == '0);
        status.slots_zero   = (slots_reg == '0);
        status.half_zero    = (half == '0);
        status.div_done     = div_done;
        status.out_free     = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = delay_reg;
    assign m_tuser  = act_reg;

endmodule
`default_nettype wire

// File: hdl/csma_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csma_ctrl: channel access sequencer
// Decodes each event against the phase, runs the divider steps of the offset
// draw and commits one result when the output register is free.
// ----------------------------------------------------------------------------
module csma_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire csma_pkg::dp_status_t  status,
    output csma_pkg::dp_cmd_t          cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TXDIV,
        S_TCA,
        S_SLOTS,
        S_SLOTDIV,
        S_SLOTCHK,
        S_REMDIV,
        S_HALV,
        S_HDIV,
        S_OUT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    csma_pkg::res_op_t  res_reg;
    csma_pkg::res_op_t  res_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_OUT;
                if (status.cmd == csma_pkg::CMD_START && status.phase == csma_pkg::PH_IDLE)
                begin
                    cmd.start_clear = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_sel     = csma_pkg::DIV_LEN_RATE;
                    state_next      = S_TXDIV;
                end
                else if (status.cmd == csma_pkg::CMD_DELAY
                         && status.phase == csma_pkg::PH_WAIT)
                begin
                    res_next = csma_pkg::RES_MEAS;
                end
                else if (status.cmd == csma_pkg::CMD_RSSI
                         && status.phase == csma_pkg::PH_MEAS)
                begin
                    if (status.chan_clear)
                    begin
                        res_next = status.check_second ? csma_pkg::RES_TX : csma_pkg::RES_GAP;
                    end
                    else if (status.guard_fail)
                    begin
                        res_next = csma_pkg::RES_FAIL_BUSY;
                    end
                    else
                    begin
                        // Re-draw a backoff inside the remaining time
                        cmd.win_busy = 1'b1;
                        res_next     = csma_pkg::RES_LAUNCH;
                        priority if (status.mode == csma_pkg::MODE_AIND
                                     || status.mode == csma_pkg::MODE_RAIND)
                        begin
                            state_next = S_SLOTS;
                        end
                        else if (status.mode == csma_pkg::MODE_RIGD)
                        begin
                            state_next = S_HALV;
                        end
                        else
                        begin
                            cmd.ofs_op = csma_pkg::OFS_ZERO;
                        end
                    end
                end
                else
                begin
                    res_next = csma_pkg::RES_REJECT;
                end
            end

            S_TXDIV:
            begin
                if (status.div_done)
                begin
                    cmd.tx_load = 1'b1;
                    state_next  = S_TCA;
                end
            end

            S_TCA:
            begin
                if (!status.tca_pos)
                begin
                    res_next   = csma_pkg::RES_FAIL_START;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.win_start = 1'b1;
                    res_next      = csma_pkg::RES_LAUNCH;
                    priority if (status.mode == csma_pkg::MODE_RAIND)
                    begin
                        state_next = S_SLOTS;
                    end
                    else if (status.mode == csma_pkg::MODE_RIGD)
                    begin
                        state_next = S_HALV;
                    end
                    else
                    begin
                        cmd.ofs_op = csma_pkg::OFS_ZERO;
                        state_next = S_OUT;
                    end
                end
            end

            S_SLOTS:
            begin
                if (status.tx_zero)
                begin
                    cmd.ofs_op = csma_pkg::OFS_ZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = csma_pkg::DIV_WIN_TX;
                    state_next    = S_SLOTDIV;
                end
            end

            S_SLOTDIV:
            begin
                if (status.div_done)
                begin
                    cmd.slots_load = 1'b1;
                    state_next     = S_SLOTCHK;
                end
            end

            S_SLOTCHK:
            begin
                if (status.slots_zero)
                begin
                    cmd.ofs_op = csma_pkg::OFS_ZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = csma_pkg::DIV_RND_SLOTS;
                    state_next    = S_REMDIV;
                end
            end

            S_REMDIV:
            begin
                if (status.div_done)
                begin
                    cmd.ofs_op = csma_pkg::OFS_MUL;
                    state_next = S_OUT;
                end
            end

            S_HALV:
            begin
                if (status.half_zero)
                begin
                    cmd.ofs_op = csma_pkg::OFS_ZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = csma_pkg::DIV_RND_HALF;
                    state_next    = S_HDIV;
                end
            end

            S_HDIV:
            begin
                if (status.div_done)
                begin
                    cmd.ofs_op = csma_pkg::OFS_REM;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // Hold the result until the output register can take it
                if (status.out_free)
                begin
                    cmd.res_op = res_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= csma_pkg::RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// File: hdl/csma_ca_channel_access.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csma_ca_channel_access: CSMA-CA channel access engine with double CCA
// Answers each start, delay-expired or RSSI event with one action.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   s_      | in        | s_tvalid/s_tready  | tuser: cmd; tdata: length, rssi,
//           |           |                    |   random value
//   m_      | out       | m_tvalid/m_tready  | tuser: action; tdata: delay ticks
//   cfg_    | in        | cfg_valid/cfg_ready| index, data
//
// One event at a time. A delay event, or an RSSI event that finds the channel
// clear or the guard time spent, is committed directly. A start first divides
// length by rate on the shared serial divider; an offset draw adds divides of
// window by slot length, random value by slot count or by halving slot.
// A stalled output holds its result; the next event is taken meanwhile and
// waits in its final step for the output register. Reset is asynchronous,
// active low, with no clearing pass. The configuration port is always ready.
// ----------------------------------------------------------------------------
module csma_ca_channel_access (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // fields from bit 0: packet_length[7:0], rssi[16:8], random_value[32:17]
    input  wire logic [csma_pkg::IN_DATA_W-1:0]   s_tdata,
    // fields from bit 0: cmd[1:0]
    input  wire logic [csma_pkg::CMD_W-1:0]       s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0: delay_ticks[15:0]
    output logic [csma_pkg::OUT_DATA_W-1:0]       m_tdata,
    // fields from bit 0: action[2:0]
    output logic [csma_pkg::ACT_W-1:0]            m_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [csma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data
);

    csma_pkg::dp_cmd_t     dp_cmd;
    csma_pkg::dp_status_t  dp_status;

    assign cfg_ready = 1'b1;

    csma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    csma_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    // An accepted event closes the input until its result is committed
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an event is in progress");

    // Only a wait action carries a delay
    a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != csma_pkg::ACT_WAIT) |-> (m_tdata == '0))
        else $error("nonzero delay on an action other than wait");

    // A commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.res_op != csma_pkg::RES_NONE) |-> dp_status.out_free)
        else $error("result committed into an occupied output register");

endmodule
`default_nettype wire
